// ----- rtl/mwma_pkg.sv -----
// Shared constants and types for the multi-window moving average.
// No dependencies; used by the channel interfaces and every module but mwma_ram.
package mwma_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int NUM_WINDOWS = 4;

  localparam int RING_AW  = $clog2(MAX_WINDOW);
  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 48;
  localparam int LEN_W    = 11;
  localparam int FILL_W   = RING_AW + 1;
  localparam int CNT_W    = 3;
  localparam int WIN_W    = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Running sums are updated one 16-bit digit per cycle
  localparam int DIGIT_W  = 16;
  localparam int DIGITS   = SUM_W / DIGIT_W;
  localparam int DIG_CW   = $clog2(DIGITS);

  // Bit-serial divider: one quotient bit per cycle over the full sum width
  localparam int DIV_CW   = $clog2(SUM_W);
  localparam int REM_W    = LEN_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SUM_W-1:0]    sum_t;
  typedef logic        [LEN_W-1:0]    len_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WINDOW_COUNT   = 3'd0,
    CFG_WINDOW_LEN_0   = 3'd1,
    CFG_WINDOW_LEN_1   = 3'd2,
    CFG_WINDOW_LEN_2   = 3'd3,
    CFG_WINDOW_LEN_3   = 3'd4,
    CFG_ERROR_SENTINEL = 3'd5
  } cfg_reg_t;

endpackage

// ----- rtl/mwma_if.sv -----
// Valid/ready channel interfaces for samples in and window means out.
// Depends on mwma_pkg.
interface mwma_in_if import mwma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mwma_out_if import mwma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_index;
  sample_t          mean_value;
  logic             last_of_run;

  modport source (output valid, output window_index, output mean_value, output last_of_run,
                  input ready);
  modport sink   (input valid, input window_index, input mean_value, input last_of_run,
                  output ready);
endinterface

// ----- rtl/mwma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mwma_div.sv -----
// Bit-serial restoring divider: signed 48-bit sum by an unsigned window length,
// truncated toward zero and saturated to 32 bits. Depends on mwma_pkg.
module mwma_div import mwma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  sum_t       dividend,
  input  len_t       divisor,
  output logic       done,
  output sample_t    quotient
);

  logic              busy_r;
  logic              fin_r;
  logic              done_r;
  logic              neg_r;
  logic [DIV_CW-1:0] cnt_r;
  sum_t              q_r;
  logic [REM_W-1:0]  rem_r;
  len_t              dvs_r;
  sample_t           res_r;

  logic [REM_W-1:0]  rem_shift;
  logic              fits;
  logic [REM_W-1:0]  rem_nxt;
  logic              too_big_neg;
  logic              too_big_pos;

  assign rem_shift = {rem_r[REM_W-2:0], q_r[SUM_W-1]};
  assign fits      = rem_shift >= {1'b0, dvs_r};
  assign rem_nxt   = fits ? rem_shift - {1'b0, dvs_r} : rem_shift;

  // magnitude above 2^31 (negative side) or above 2^31-1 (positive side)
  assign too_big_neg = (|q_r[SUM_W-1:SAMPLE_W]) ||
                       (q_r[SAMPLE_W-1] && (|q_r[SAMPLE_W-2:0]));
  assign too_big_pos = (|q_r[SUM_W-1:SAMPLE_W]) || q_r[SAMPLE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r  <= !start && busy_r && (cnt_r == DIV_CW'(SUM_W - 1));
      done_r <= !start && !busy_r && fin_r;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[SUM_W-1];
        q_r    <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        q_r   <= {q_r[SUM_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(SUM_W - 1)) begin
          busy_r <= 1'b0;
        end
      end else if (fin_r) begin
        if (neg_r) begin
          res_r <= too_big_neg ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                               : sample_t'(~q_r[SAMPLE_W-1:0] + 1'b1);
        end else begin
          res_r <= too_big_pos ? {1'b0, {(SAMPLE_W-1){1'b1}}}
                               : sample_t'(q_r[SAMPLE_W-1:0]);
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = res_r;

endmodule

// ----- rtl/multi_window_moving_average.sv -----
// Multi-window moving average over signed Q16.16 samples.
// Input channel in_ch: one sample per transfer. Output channel out_ch: one
// mean per enabled window, window 0 first, last_of_run set on the final one.
// A sample equal to error_sentinel, or any sample while window_count is zero,
// is taken and dropped with no result.
// Configuration: cfg_we/cfg_index/cfg_wdata write registers 0..5 (window
// count, four window lengths, sentinel); write only while the block is idle.
// Per window the sequencer reads the leaving sample from the history RAM,
// updates the running sum one 16-bit digit per cycle, then runs the
// bit-serial divider (load, 48 quotient bits, sign fix and saturate,
// hand-back) and moves the result to the output register. After the last
// window it writes the sample to the history RAM. in_ch.ready is high only
// while the sequencer is idle.
// The output register frees the sequencer: a stalled receiver holds out_ch
// stable and only blocks the next result hand-off, not the work before it.
// Reset clears the running sums, write position, fill count and window count,
// and sets the window lengths to 1 and the sentinel to 0x80000000; the history
// RAM is not cleared since an entry is only read once written.
// Depends on mwma_pkg, mwma_if, mwma_ram and mwma_div.
module multi_window_moving_average import mwma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mwma_in_if.sink           in_ch,
  mwma_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_ADD, S_DIV, S_EMIT, S_STORE
  } state_t;

  state_t             state_r;

  logic [CNT_W-1:0]   window_count_r;
  len_t               len_r [NUM_WINDOWS];
  sample_t            sentinel_r;

  sum_t               sums_r [NUM_WINDOWS];
  logic [RING_AW-1:0] wp_r;
  logic [FILL_W-1:0]  fill_r;

  sample_t            sample_r;
  logic [WIN_W-1:0]   k_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIG_CW-1:0]  dig_r;
  logic [1:0]         carry_r;
  sum_t               sum_sh_r;
  sum_t               v_sh_r;
  sum_t               old_sh_r;
  logic               div_start_r;

  logic               out_valid_r;
  logic [WIN_W-1:0]   out_index_r;
  sample_t            out_mean_r;
  logic               out_last_r;

  logic [CNT_W-1:0]   count_lim;
  len_t               len_raw;
  len_t               len_eff;
  logic               have_old;
  len_t               denom;
  logic [RING_AW-1:0] rd_addr;
  sample_t            ram_rdata;
  logic               ram_we;
  logic [DIGIT_W+1:0] digit_sum;
  logic               last_win;
  logic               div_done;
  sample_t            div_q;

  assign count_lim = (window_count_r > CNT_W'(NUM_WINDOWS)) ? CNT_W'(NUM_WINDOWS)
                                                             : window_count_r;

  assign len_raw = len_r[k_r];
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_raw > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = len_raw;
    end
  end

  assign have_old = LEN_W'(fill_r) >= len_eff;
  // fill + 1 is below the length only while it still fits the length width
  assign denom    = (({1'b0, fill_r} + 1'b1) < {1'b0, len_eff}) ? LEN_W'(fill_r + 1'b1)
                                                                 : len_eff;
  assign rd_addr  = wp_r - len_eff[RING_AW-1:0];

  // three-operand digit add: sum + sample - leaving sample
  assign digit_sum = {2'b00, sum_sh_r[DIGIT_W-1:0]} + {2'b00, v_sh_r[DIGIT_W-1:0]} +
                     {2'b00, ~old_sh_r[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, carry_r};

  assign last_win = (({1'b0, k_r}) + 1'b1) == cnt_r;
  assign ram_we   = (state_r == S_STORE);

  mwma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(sample_r),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  mwma_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .dividend(sum_sh_r),
    .divisor (denom),
    .done    (div_done),
    .quotient(div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_count_r <= '0;
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        len_r[i] <= LEN_W'(1);
      end
      sentinel_r <= {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_COUNT:   window_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_WINDOW_LEN_0:   len_r[0] <= cfg_wdata[LEN_W-1:0];
        CFG_WINDOW_LEN_1:   len_r[1] <= cfg_wdata[LEN_W-1:0];
        CFG_WINDOW_LEN_2:   len_r[2] <= cfg_wdata[LEN_W-1:0];
        CFG_WINDOW_LEN_3:   len_r[3] <= cfg_wdata[LEN_W-1:0];
        CFG_ERROR_SENTINEL: sentinel_r <= cfg_wdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WINDOWS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      // in S_EMIT the hand-off below decides the output valid
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && count_lim != '0 && in_ch.sample != sentinel_r) begin
            sample_r <= in_ch.sample;
            k_r      <= '0;
            cnt_r    <= count_lim;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          sum_sh_r <= sums_r[k_r];
          v_sh_r   <= {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
          old_sh_r <= have_old ? {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata}
                               : '0;
          carry_r  <= 2'd1;
          dig_r    <= '0;
          state_r  <= S_ADD;
        end
        S_ADD: begin
          sum_sh_r <= {digit_sum[DIGIT_W-1:0], sum_sh_r[SUM_W-1:DIGIT_W]};
          v_sh_r   <= v_sh_r >> DIGIT_W;
          old_sh_r <= old_sh_r >> DIGIT_W;
          carry_r  <= digit_sum[DIGIT_W+1:DIGIT_W];
          dig_r    <= dig_r + 1'b1;
          if (dig_r == DIG_CW'(DIGITS - 1)) begin
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_start_r) begin
            sums_r[k_r] <= sum_sh_r;
            div_start_r <= 1'b0;
          end
          if (div_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_index_r <= k_r;
            out_mean_r  <= div_q;
            out_last_r  <= last_win;
            if (last_win) begin
              state_r <= S_STORE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_STORE: begin
          wp_r <= wp_r + 1'b1;
          if (fill_r != FILL_W'(MAX_WINDOW)) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.window_index = out_index_r;
  assign out_ch.mean_value   = out_mean_r;
  assign out_ch.last_of_run  = out_last_r;

endmodule

// ----- sim/multi_window_moving_average_tb.sv -----
`timescale 1ns / 1ps
// Testbench for multi_window_moving_average: directed and random samples over
// changing window settings, checked against a running-sum predictor.
// Depends on mwma_pkg, the mwma_in_if / mwma_out_if channel interfaces and the top module.

module multi_window_moving_average_tb;
  import mwma_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int ITEMS         = 430;
  localparam int FILL_RUN      = 64;
  localparam int QUIET_TAIL    = 60;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 600;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PRINT_LIMIT   = 50;

  localparam longint MEAN_MAX = 64'sd2147483647;
  localparam longint MEAN_MIN = -64'sd2147483648;

  // Indexes past the register map; writes there must change nothing
  localparam logic [CFG_AW-1:0] CFG_NO_REG_6 = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_NO_REG_7 = 3'd7;

  typedef struct {
    logic [WIN_W-1:0] window_index;
    sample_t          mean_value;
    logic             last_of_run;
  } window_mean_t;

  class window_mean_checker;
    logic [CNT_W-1:0] window_count;
    len_t             window_len[NUM_WINDOWS];
    sample_t          error_sentinel;
    sample_t          history[MAX_WINDOW];
    sum_t             running_sum[NUM_WINDOWS];
    int unsigned      write_pos;
    int unsigned      fill_count;
    window_mean_t     pending_means[$];
    int unsigned      mismatches;

    function new();
      window_count   = '0;
      error_sentinel = sample_t'(32'h8000_0000);
      foreach (window_len[k]) window_len[k] = len_t'(1);
      foreach (running_sum[k]) running_sum[k] = '0;
      foreach (history[k]) history[k] = '0;
      write_pos  = 0;
      fill_count = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] index, logic [CFG_DW-1:0] data);
      case (index)
        CFG_WINDOW_COUNT:   window_count   = data[CNT_W-1:0];
        CFG_WINDOW_LEN_0:   window_len[0]  = data[LEN_W-1:0];
        CFG_WINDOW_LEN_1:   window_len[1]  = data[LEN_W-1:0];
        CFG_WINDOW_LEN_2:   window_len[2]  = data[LEN_W-1:0];
        CFG_WINDOW_LEN_3:   window_len[3]  = data[LEN_W-1:0];
        CFG_ERROR_SENTINEL: error_sentinel = data;
        default: ;
      endcase
    endfunction

    // Queues one mean per enabled window; returns how many were queued
    function int unsigned predict_means(sample_t s);
      int unsigned  active, len, denom, slot;
      int           k;
      longint       acc, mean;
      window_mean_t r;
      active = (window_count > NUM_WINDOWS) ? NUM_WINDOWS : window_count;
      if (active == 0 || s == error_sentinel) return 0;
      for (k = 0; k < active; k++) begin
        len = window_len[k];
        if (len == 0) len = 1;
        if (len > MAX_WINDOW) len = MAX_WINDOW;
        acc = longint'($signed(running_sum[k])) + longint'(s);
        // oldest sample drops out only once the window has filled
        if (fill_count >= len) begin
          slot = (write_pos + MAX_WINDOW - len) % MAX_WINDOW;
          acc -= longint'(history[slot]);
        end
        running_sum[k] = acc[SUM_W-1:0];
        denom = (fill_count + 1 < len) ? fill_count + 1 : len;
        mean  = longint'($signed(running_sum[k])) / longint'(denom);
        if (mean > MEAN_MAX) mean = MEAN_MAX;
        if (mean < MEAN_MIN) mean = MEAN_MIN;
        r.window_index = k[WIN_W-1:0];
        r.mean_value   = mean[SAMPLE_W-1:0];
        r.last_of_run  = (k + 1 == active);
        pending_means.push_back(r);
      end
      history[write_pos] = s;
      write_pos = (write_pos + 1) % MAX_WINDOW;
      if (fill_count < MAX_WINDOW) fill_count++;
      return active;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_mean(logic [WIN_W-1:0] win, sample_t mean, logic last);
      window_mean_t want;
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("unexpected mean: window %0d value %0d last %b",
                                  win, mean, last));
        return;
      end
      want = pending_means.pop_front();
      if (win !== want.window_index)
        report_mismatch($sformatf("window_index %0d, want %0d", win, want.window_index));
      if (mean !== want.mean_value)
        report_mismatch($sformatf("window %0d mean_value %0d, want %0d",
                                  want.window_index, mean, want.mean_value));
      if (last !== want.last_of_run)
        report_mismatch($sformatf("window %0d last_of_run %b, want %b",
                                  want.window_index, last, want.last_of_run));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  mwma_in_if  in_ch();
  mwma_out_if out_ch();

  window_mean_checker board = new();

  bit          idling = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned sent_items = 0;
  int unsigned cycle_count;

  multi_window_moving_average dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_mean(out_ch.window_index, out_ch.mean_value, out_ch.last_of_run);
    end
  end

  // Result side: ready bursts, random stalls, and one long hold on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout after %0d cycles", $time, cycle_count);
    $display("Verification failed");
    $finish;
  end

  // valid stays high after a transfer; the next call or settle decides its level
  task automatic send_sample(input sample_t s);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    void'(board.predict_means(s));
    sent_items++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] index, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    board.write_reg(index, data);
  endtask

  // Upper data bits beyond each register's width are random and must be dropped
  task automatic set_windows(input int unsigned count, input int unsigned l0, l1, l2, l3,
                             input logic [CFG_DW-1:0] sentinel);
    int unsigned       lens[NUM_WINDOWS];
    logic [CFG_DW-1:0] data;
    int                k;
    lens = '{l0, l1, l2, l3};
    settle();
    write_reg($urandom_range(0, 1) ? CFG_NO_REG_6 : CFG_NO_REG_7, $urandom);
    data = $urandom;
    data[CNT_W-1:0] = count[CNT_W-1:0];
    write_reg(CFG_WINDOW_COUNT, data);
    for (k = 0; k < NUM_WINDOWS; k++) begin
      data = $urandom;
      data[LEN_W-1:0] = lens[k][LEN_W-1:0];
      write_reg(CFG_AW'(CFG_WINDOW_LEN_0 + k), data);
    end
    write_reg(CFG_ERROR_SENTINEL, sentinel);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return board.error_sentinel;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return '0;
          3:       return '1;
          default: return 32'sd1;
        endcase
      end
      2, 3: return sample_t'(int'($urandom_range(0, 262143)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 0 : 2047;
      1:       return $urandom_range(0, 1) ? MAX_WINDOW : 1;
      2:       return $urandom_range(0, 2047);
      3, 4:    return $urandom_range(9, 64);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned pick_count();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return $urandom_range(NUM_WINDOWS + 1, 7);
      default: return $urandom_range(1, NUM_WINDOWS);
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_sentinel();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned count;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset no window is enabled, so these are dropped
    send_sample(32'h1234_5678);
    send_sample(32'h8000_0000);

    set_windows(4, 1, 2, 3, 4, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample('0);
    send_sample(32'sd1);
    send_sample(32'h8000_0001);
    send_sample(32'h7FFF_FFFF);

    // count above four, length zero and length above the ring depth all clamp
    set_windows(7, 0, 2047, MAX_WINDOW, 5, '0);
    send_sample('0);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_0000);

    // shrinking a long window leaves stale samples in its sum: the mean saturates
    set_windows(2, MAX_WINDOW, MAX_WINDOW, 1, 1, 32'hDEAD_BEEF);
    repeat (3) send_sample(32'h7FFF_FFFF);
    set_windows(2, 1, 2, 1, 1, 32'hDEAD_BEEF);
    send_sample(32'h7FFF_FFFF);
    set_windows(3, MAX_WINDOW, MAX_WINDOW, 3, 1, 32'hDEAD_BEEF);
    repeat (5) send_sample(32'h8000_0001);
    set_windows(3, 1, 2, 3, 1, 32'hDEAD_BEEF);
    send_sample(32'h8000_0000);

    // one full-depth window over a longer run while it is still filling
    set_windows(1, MAX_WINDOW, pick_len(), pick_len(), pick_len(), pick_sentinel());
    repeat (FILL_RUN) send_sample(pick_sample());

    phase = 0;
    while (sent_items < ITEMS) begin
      if (sent_items + QUIET_TAIL >= ITEMS) idling = 1'b0;
      count = (phase == 1) ? NUM_WINDOWS : pick_count();
      set_windows(count, pick_len(), pick_len(), pick_len(), pick_len(), pick_sentinel());
      // receiver stops while the sender keeps offering: block backs up to its input
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(15, 50)) send_sample(pick_sample());
      phase++;
    end

    settle();
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
